### src/rorm_pkg.sv
`default_nettype none

package rorm_pkg;

  typedef enum logic [1:0] {
    CMD_RESERVE = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_CHECK   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REASON_UNKNOWN    = 2'd0,
    REASON_MMU_ABSENT = 2'd1,
    REASON_FPU_ABSENT = 2'd2
  } reason_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    REG_MMU_PRESENT = 2'd0,
    REG_CPU_040     = 2'd1,
    REG_FPU_PRESENT = 2'd2
  } reg_idx_t;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned COP_LSB  = 9;
  localparam int unsigned COP_W    = 3;
  localparam logic [COP_W-1:0] COP_MMU = 3'd0;
  localparam logic [COP_W-1:0] COP_FPU = 3'd1;
  localparam logic [WORD_W-1:0] PAGE_MASK   = 16'hFF00;
  localparam logic [WORD_W-1:0] PAGE_MMU040 = 16'hF500;

  function automatic reason_t fline_reason(input logic [WORD_W-1:0] word,
                                           input logic mmu_present,
                                           input logic cpu_040,
                                           input logic fpu_present);
    logic [COP_W-1:0] cop;
    reason_t          res;
    cop = word[COP_LSB +: COP_W];
    res = REASON_UNKNOWN;
    if (!mmu_present && cop == COP_MMU) begin
      res = REASON_MMU_ABSENT;
    end else if (!mmu_present && cpu_040 && (word & PAGE_MASK) == PAGE_MMU040) begin
      res = REASON_MMU_ABSENT;
    end else if (cop == COP_FPU && !fpu_present) begin
      res = REASON_FPU_ABSENT;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### src/reserved_opcode_range_matcher_top.sv
`default_nettype none

// reserved opcode range matcher
// keeps up to MAX_RANGES inclusive 16-bit opcode ranges in a synchronous ram
// and answers one command per transaction on the in_ channel:
//   reserve appends [in_range_start, in_range_end]; status 1 when end < start
//   or the table is full; clear empties the table; check tests in_opcode_word
//   against every stored range and gives the line-f reason
// a transaction is accepted at a clock edge with start high and busy low
// each result is shown for one cycle with out_valid high; the receiver cannot
// stall, so nothing is held back
// reserve, clear and check on an empty table: result in the next cycle, busy
// stays low, so a new transaction can follow every cycle
// check with N stored ranges: the ram is read one entry per cycle, so busy
// is high through the scan and drain states, and the result is registered after drain
// config registers sit on the apb port: mmu_present at 0x0,
// cpu_is_040_or_later at 0x4, fpu_present at 0x8; write only while idle
// reset (rst_n low, synchronous) empties the table and clears the config registers;
// table contents are not cleared and are only read below the fill count
module reserved_opcode_range_matcher_top #(
  parameter int unsigned MAX_RANGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_range_start,
  input  wire logic [15:0] in_range_end,
  input  wire logic [15:0] in_opcode_word,
  output logic             out_valid,
  output logic             out_status,
  output logic             out_is_reserved,
  output logic [1:0]       out_fline_reason,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned ENT_W = 2 * rorm_pkg::WORD_W;

  rorm_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic              hit_r, hit_nxt;
  logic [15:0]       word_r, word_nxt;
  rorm_pkg::reason_t reason_r, reason_nxt;

  logic              mmu_r, cpu040_r, fpu_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [1:0]        out_reason_r, out_reason_nxt;

  logic              accept;
  logic              cfg_wr;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  logic              match;
  logic              idx_last;

  rorm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_RANGES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mmu_r    <= 1'b0;
      cpu040_r <= 1'b0;
      fpu_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (rorm_pkg::reg_idx_t'(paddr[3:2]))
        rorm_pkg::REG_MMU_PRESENT: mmu_r    <= pwdata[0];
        rorm_pkg::REG_CPU_040:     cpu040_r <= pwdata[0];
        rorm_pkg::REG_FPU_PRESENT: fpu_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (rorm_pkg::reg_idx_t'(paddr[3:2]))
      rorm_pkg::REG_MMU_PRESENT: prdata[0] = mmu_r;
      rorm_pkg::REG_CPU_040:     prdata[0] = cpu040_r;
      rorm_pkg::REG_FPU_PRESENT: prdata[0] = fpu_r;
      default:                   prdata    = '0;
    endcase
  end

  // command handling
  assign busy     = (state_r != rorm_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign match    = (word_r >= ram_rdata[rorm_pkg::WORD_W-1:0]) &&
                    (word_r <= ram_rdata[ENT_W-1:rorm_pkg::WORD_W]);
  assign idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign ram_waddr = count_r[IDX_W-1:0];
  assign ram_wdata = {in_range_end, in_range_start};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    hit_nxt        = hit_r;
    word_nxt       = word_r;
    reason_nxt     = reason_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = 1'b0;
    out_hit_nxt    = 1'b0;
    out_reason_nxt = rorm_pkg::REASON_UNKNOWN;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    case (state_r)
      rorm_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (rorm_pkg::cmd_t'(in_cmd))
            rorm_pkg::CMD_RESERVE: begin
              if (in_range_end < in_range_start || count_r >= CNT_W'(MAX_RANGES)) begin
                out_status_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            rorm_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            rorm_pkg::CMD_CHECK: begin
              word_nxt   = in_opcode_word;
              reason_nxt = rorm_pkg::fline_reason(in_opcode_word, mmu_r, cpu040_r, fpu_r);
              if (count_r == '0) begin
                out_reason_nxt = reason_nxt;
              end else begin
                out_valid_nxt = 1'b0;
                idx_nxt       = '0;
                hit_nxt       = 1'b0;
                state_nxt     = rorm_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      rorm_pkg::ST_SCAN: begin
        ram_re   = 1'b1;
        pend_nxt = 1'b1;
        if (pend_r && match) begin
          hit_nxt = 1'b1;
        end
        if (idx_last) begin
          state_nxt = rorm_pkg::ST_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      rorm_pkg::ST_DRAIN: begin
        out_valid_nxt  = 1'b1;
        out_hit_nxt    = hit_r || (pend_r && match);
        out_reason_nxt = reason_r;
        state_nxt      = rorm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rorm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rorm_pkg::ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    word_r       <= word_nxt;
    reason_r     <= reason_nxt;
    out_status_r <= out_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_reason_r <= out_reason_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_is_reserved  = out_hit_r;
  assign out_fline_reason = out_reason_r;

`ifndef ASSERT_OFF
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RANGES))
    else $error("range count above table depth");

  a_check_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == rorm_pkg::CMD_CHECK && count_r != '0) |=> (busy && !out_valid))
    else $error("check on filled table did not start a scan");

  a_other_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd != rorm_pkg::CMD_CHECK) |=> (out_valid && !busy))
    else $error("non-check transaction missed its result");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rorm_pkg::ST_SCAN) |-> (CNT_W'(idx_r) < count_r))
    else $error("scan index beyond fill count");
`endif

endmodule

`default_nettype wire

### src/rorm_ram.sv
`default_nettype none

module rorm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
